@@ rtl/core/cuq_pkg.sv @@
// ---------------------------------------------------------------------------
// cuq_pkg: shared types and constants of the coalescing update queue
// Field widths, request and status codes, register indexes, sequencer
// states and the byte mask helper.
// ---------------------------------------------------------------------------
package cuq_pkg;

    // Field widths of one word
    localparam int KEY_W     = 32;
    localparam int IDX_W     = 5;
    localparam int SIZE_W    = 8;
    localparam int ESIZE_W   = 4;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 3;

    // Request codes
    localparam logic REQ_POST = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_AWAKE  = 1'b0;
    localparam logic CFG_IGNORE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_FULL     = 3'd4,
        ST_POPPED   = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POP
    } state_t;

    // Mask covering the low n bytes of a payload word
    function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [ESIZE_W-1:0] n);
        logic [PAYLOAD_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_W / 8; b++)
        begin
            m[8*b +: 8] = (ESIZE_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/cuq_ram.sv @@
// ---------------------------------------------------------------------------
// cuq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module cuq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/coalescing_update_queue_top.sv @@
// ---------------------------------------------------------------------------
// coalescing_update_queue_top: bounded FIFO of key writes that merges repeats
//
// Command channel: a word is taken at a clock edge with start high and busy
// low. req_type selects a post (key, entry_index, data_size, payload, forced)
// or a pop of the oldest entry. Exactly one result word follows, shown for
// one cycle with done high; the receiver cannot stall it. occupancy always
// shows the current entry count and is valid with done.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 awake,
// 1 ignore_posts) at the clock edge; write only while the block is idle.
// A refused post or an unserved pop answers in the cycle after accept, a pop
// once S_POP has taken the oldest entry from the RAM. A post searches the queue
// one entry per cycle through the single read port of the entry RAM: done comes
// once the search has passed every queued entry, or earlier on a merge hit.
// busy is high until the result cycle, so a new word can be taken in the
// cycle done is high. Reset empties the queue, sets awake and clears
// ignore_posts; no clearing pass is needed since only queued slots are read.
// ---------------------------------------------------------------------------
module coalescing_update_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_BYTES  = 8,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [cuq_pkg::KEY_W-1:0]           key,
    input  logic signed [cuq_pkg::IDX_W-1:0]    entry_index,
    input  logic [cuq_pkg::SIZE_W-1:0]          data_size,
    input  logic [cuq_pkg::PAYLOAD_W-1:0]       payload,
    input  logic                                forced,
    // result channel
    output logic                                done,
    output logic [cuq_pkg::STATUS_W-1:0]        status,
    output logic [cuq_pkg::KEY_W-1:0]           out_key,
    output logic signed [cuq_pkg::IDX_W-1:0]    out_index,
    output logic [cuq_pkg::ESIZE_W-1:0]         out_size,
    output logic [cuq_pkg::PAYLOAD_W-1:0]       out_data,
    output logic [CNT_W-1:0]                    occupancy,
    // configuration port
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic                                cfg_wdata
);

    import cuq_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DATA_W  = 8 * DATA_BYTES;
    localparam int ENTRY_W = KEY_W + IDX_W + ESIZE_W + DATA_W;
    // Entry word layout: key | index | size | data
    localparam int SIZE_LO = DATA_W;
    localparam int IDX_LO  = DATA_W + ESIZE_W;
    localparam int KEY_LO  = DATA_W + ESIZE_W + IDX_W;

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [KEY_W-1:0]       out_key_reg, out_key_next;
    logic [IDX_W-1:0]       out_index_reg, out_index_next;
    logic [ESIZE_W-1:0]     out_size_reg, out_size_next;
    logic [PAYLOAD_W-1:0]   out_data_reg, out_data_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic                   awake_reg, awake_next;
    logic                   ignore_reg, ignore_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [ESIZE_W-1:0]     size_reg, size_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic [CNT_W-1:0]       issue_pos_reg, issue_pos_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [PTR_W-1:0]       cmp_slot_reg, cmp_slot_next;

    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [KEY_W-1:0]       rd_key;
    logic [IDX_W-1:0]       rd_idx;
    logic [ESIZE_W-1:0]     rd_size;
    logic [DATA_W-1:0]      rd_data;
    logic                   hit;
    logic [DATA_W-1:0]      new_mask;
    logic [DATA_W-1:0]      size_mask;

    // Slot of queue position pos, wrapped once around the ring
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = {1'b0, pos} + (CNT_W+1)'(head);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Entry storage
    cuq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Split the read word and compare it against the pending post
    assign rd_key    = ram_rdata[KEY_LO +: KEY_W];
    assign rd_idx    = ram_rdata[IDX_LO +: IDX_W];
    assign rd_size   = ram_rdata[SIZE_LO +: ESIZE_W];
    assign rd_data   = ram_rdata[DATA_W-1:0];
    assign hit       = cmp_valid_reg && (rd_key == key_reg) && (rd_idx == idx_reg);
    assign new_mask  = DATA_W'(byte_mask(data_size[ESIZE_W-1:0]));
    assign size_mask = DATA_W'(byte_mask(size_reg));

    // Sequencer: next state, RAM control and result
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_key_next   = out_key_reg;
        out_index_next = out_index_reg;
        out_size_next  = out_size_reg;
        out_data_next  = out_data_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        awake_next     = awake_reg;
        ignore_next    = ignore_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        size_next      = size_reg;
        data_next      = data_reg;
        issue_pos_next = issue_pos_reg;
        cmp_valid_next = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        ram_we         = 1'b0;
        ram_waddr      = cmp_slot_reg;
        ram_wdata      = {key_reg, idx_reg, size_reg, data_reg};
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_AWAKE:  awake_next  = cfg_wdata;
                CFG_IGNORE: ignore_next = cfg_wdata;
                default:    awake_next  = awake_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Clear popped fields; a pop fills them later
                    out_key_next   = '0;
                    out_index_next = '0;
                    out_size_next  = '0;
                    out_data_next  = '0;
                    if (req_type == REQ_POST)
                    begin
                        if (!forced && (!awake_reg || ignore_reg))
                        begin
                            status_next = ST_IGNORED;
                            done_next   = 1'b1;
                        end
                        else if (data_size > SIZE_W'(DATA_BYTES))
                        begin
                            status_next = ST_TOO_BIG;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // Latch the post and start the search at the head
                            key_next       = key;
                            idx_next       = entry_index;
                            size_next      = data_size[ESIZE_W-1:0];
                            data_next      = payload[DATA_W-1:0] & new_mask;
                            issue_pos_next = '0;
                            state_next     = S_SEARCH;
                        end
                    end
                    else if (awake_reg && (count_reg != '0))
                    begin
                        // Read the oldest entry
                        ram_re     = 1'b1;
                        ram_raddr  = head_reg;
                        state_next = S_POP;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                        done_next   = 1'b1;
                    end
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    // Merge in place: replace the low bytes, keep the rest
                    ram_we      = 1'b1;
                    ram_waddr   = cmp_slot_reg;
                    ram_wdata   = {key_reg, idx_reg, size_reg,
                                   (rd_data & ~size_mask) | data_reg};
                    status_next = ST_MERGED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (issue_pos_reg == count_reg)
                begin
                    // No match: append at the tail unless full
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = slot_of(head_reg, count_reg);
                        count_next  = count_reg + 1'b1;
                        status_next = ST_APPENDED;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Advance: read the next queued entry
                    ram_re         = 1'b1;
                    ram_raddr      = slot_of(head_reg, issue_pos_reg);
                    issue_pos_next = issue_pos_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = ram_raddr;
                end
            end

            S_POP:
            begin
                // Return the oldest entry and drop it
                out_key_next   = rd_key;
                out_index_next = rd_idx;
                out_size_next  = rd_size;
                out_data_next  = '0;
                out_data_next[DATA_W-1:0] = rd_data;
                head_next      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : head_reg + 1'b1;
                count_next     = count_reg - 1'b1;
                status_next    = ST_POPPED;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            awake_reg     <= 1'b1;
            ignore_reg    <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            awake_reg     <= awake_next;
            ignore_reg    <= ignore_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_key_reg   <= out_key_next;
        out_index_reg <= out_index_next;
        out_size_reg  <= out_size_next;
        out_data_reg  <= out_data_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        size_reg      <= size_next;
        data_reg      <= data_next;
        issue_pos_reg <= issue_pos_next;
        cmp_slot_reg  <= cmp_slot_next;
    end

    // Outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign out_index = out_index_reg;
    assign out_size  = out_size_reg;
    assign out_data  = out_data_reg;
    assign occupancy = count_reg;

`ifndef SYNTHESIS
    a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SEARCH))
        else $error("entry RAM written outside the search");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (issue_pos_reg <= count_reg))
        else $error("search ran past the queued entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_POPPED))
            |-> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("pop did not drop one entry");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result shown while still busy");
`endif

endmodule
